[sv/tchfb_pkg.sv]
// Package for the TCP client frame builder: payload structs, codes and constants.
// No dependencies.
package tchfb_pkg;

    localparam logic [1:0] FUNC_OPEN = 2'd0;
    localparam logic [1:0] FUNC_RX   = 2'd1;
    localparam logic [1:0] FUNC_SEND = 2'd2;

    localparam logic [1:0] VERD_IGNORED  = 2'd0;
    localparam logic [1:0] VERD_ACCEPTED = 2'd1;
    localparam logic [1:0] VERD_REFUSED  = 2'd2;

    localparam logic [2:0] REG_OWN_MAC   = 3'd0;
    localparam logic [2:0] REG_OWN_IP    = 3'd1;
    localparam logic [2:0] REG_PEER_MAC  = 3'd2;
    localparam logic [2:0] REG_PEER_IP   = 3'd3;
    localparam logic [2:0] REG_PEER_PORT = 3'd4;

    localparam logic [1:0] PHASE_CLOSED   = 2'd0;
    localparam logic [1:0] PHASE_SYN_SENT = 2'd1;
    localparam logic [1:0] PHASE_ESTAB    = 2'd2;

    localparam logic [15:0] FLAG_SYN = 16'h0002;
    localparam logic [15:0] FLAG_PSH = 16'h0008;
    localparam logic [15:0] FLAG_ACK = 16'h0010;

    localparam logic [15:0] FLAGS_SYN     = 16'h5002;
    localparam logic [15:0] FLAGS_ACK     = 16'h5010;
    localparam logic [15:0] FLAGS_PSH_ACK = 16'h5018;
    localparam logic [15:0] WINDOW_SYN    = 16'd29200;
    localparam logic [15:0] WINDOW_EST    = 16'd229;
    localparam logic [15:0] ETHERTYPE_IP  = 16'h0800;
    localparam logic [15:0] IP_VER_TOS    = 16'h4500;
    localparam logic [15:0] IP_TTL_PROTO  = 16'h4006;
    localparam logic [15:0] PROTO_TCP     = 16'h0006;
    localparam logic [15:0] HDR_BYTES     = 16'd40;
    localparam logic [15:0] TCP_HDR_BYTES = 16'd20;
    localparam logic [4:0]  FRAME_WORDS   = 5'd27;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] start_id;
        logic [15:0] start_port;
        logic [31:0] start_seq;
        logic [15:0] rx_flags;
        logic [31:0] rx_seq;
        logic [31:0] rx_ack;
        logic [15:0] rx_total_length;
        logic [10:0] payload_length;
        logic [15:0] payload_sum;
    } in_item_t;

    typedef struct packed {
        logic        item_kind;
        logic [15:0] frame_word;
        logic        last_word;
        logic [1:0]  verdict;
        logic [15:0] data_length;
    } out_item_t;

    // One classified command handed from the front to the back.
    typedef struct packed {
        logic        is_frame;
        logic [1:0]  verdict;
        logic [15:0] data_length;
        logic [15:0] ident;
        logic [15:0] lport;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [15:0] flags;
        logic [15:0] window;
        logic [10:0] plen;
        logic [15:0] psum;
    } job_t;

    // End-around-carry 16-bit add.
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

[sv/tchfb_front.sv]
// Front part: accepts commands, runs the connection state and classifies each one.
// Depends on tchfb_pkg.
module tchfb_front #(
    parameter int MAX_PAYLOAD = 1460
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tchfb_pkg::in_item_t in_data,
    output logic               job_valid,
    input  logic               job_ready,
    output tchfb_pkg::job_t    job
);
    import tchfb_pkg::*;

    logic [1:0]  phase_reg, phase_next;
    logic [15:0] ident_reg, ident_next;
    logic [15:0] lport_reg, lport_next;
    logic [31:0] seq_reg, seq_next;
    logic [31:0] ack_reg, ack_next;
    logic        jv_reg;
    job_t        job_reg, job_next;
    logic        take;
    logic        syn_ok, data_ok;
    logic [10:0] plen_sat;
    logic [15:0] rx_len;

    assign in_ready  = !jv_reg || job_ready;
    assign take      = in_valid && in_ready;
    assign job_valid = jv_reg;
    assign job       = job_reg;

    assign syn_ok  = (phase_reg == PHASE_SYN_SENT) && |(in_data.rx_flags & FLAG_SYN)
                     && |(in_data.rx_flags & FLAG_ACK) && (in_data.rx_ack == seq_reg);
    assign data_ok = (phase_reg == PHASE_ESTAB) && |(in_data.rx_flags & FLAG_PSH)
                     && |(in_data.rx_flags & FLAG_ACK) && (in_data.rx_seq == ack_reg);
    assign plen_sat = (in_data.payload_length > 11'(MAX_PAYLOAD)) ? 11'(MAX_PAYLOAD)
                      : in_data.payload_length;
    assign rx_len = (in_data.rx_total_length > HDR_BYTES)
                    ? in_data.rx_total_length - HDR_BYTES : 16'd0;

    // Classify one command and advance the connection state.
    always_comb
    begin
        phase_next = phase_reg;
        ident_next = ident_reg;
        lport_next = lport_reg;
        seq_next   = seq_reg;
        ack_next   = ack_reg;
        job_next   = '0;
        job_next.ident = ident_reg;
        job_next.lport = lport_reg;
        job_next.seq   = seq_reg;
        job_next.ack   = ack_reg;
        job_next.window = WINDOW_EST;
        unique case (in_data.func)
            FUNC_OPEN:
            begin
                job_next.is_frame = 1'b1;
                job_next.ident  = in_data.start_id;
                job_next.lport  = in_data.start_port;
                job_next.seq    = in_data.start_seq;
                job_next.ack    = '0;
                job_next.flags  = FLAGS_SYN;
                job_next.window = WINDOW_SYN;
                ident_next = in_data.start_id + 16'd1;
                lport_next = in_data.start_port;
                seq_next   = in_data.start_seq + 32'd1;
                ack_next   = '0;
                phase_next = PHASE_SYN_SENT;
            end
            FUNC_RX:
            begin
                if (syn_ok)
                begin
                    job_next.is_frame = 1'b1;
                    job_next.ack   = in_data.rx_seq + 32'd1;
                    job_next.flags = FLAGS_ACK;
                    ack_next   = in_data.rx_seq + 32'd1;
                    ident_next = ident_reg + 16'd1;
                    phase_next = PHASE_ESTAB;
                end
                else if (data_ok)
                begin
                    job_next.verdict     = VERD_ACCEPTED;
                    job_next.data_length = rx_len;
                    ack_next = ack_reg + {16'd0, rx_len};
                end
            end
            FUNC_SEND:
            begin
                if (phase_reg == PHASE_ESTAB)
                begin
                    job_next.is_frame = 1'b1;
                    job_next.flags = FLAGS_PSH_ACK;
                    job_next.plen  = plen_sat;
                    job_next.psum  = in_data.payload_sum;
                    ident_next = ident_reg + 16'd1;
                    seq_next   = seq_reg + {21'd0, plen_sat};
                end
                else
                begin
                    job_next.verdict = VERD_REFUSED;
                end
            end
            default:
            begin
                job_next.verdict = VERD_IGNORED;
            end
        endcase
    end

    // State and job registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_CLOSED;
            ident_reg <= '0;
            lport_reg <= '0;
            seq_reg   <= '0;
            ack_reg   <= '0;
            jv_reg    <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg <= phase_next;
                ident_reg <= ident_next;
                lport_reg <= lport_next;
                seq_reg   <= seq_next;
                ack_reg   <= ack_next;
                jv_reg    <= 1'b1;
            end
            else if (job_ready)
            begin
                jv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg <= job_next;
        end
    end

endmodule

[sv/tchfb_queue.sv]
// Short job queue between the front and the back.
// Depends on tchfb_pkg.
module tchfb_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  tchfb_pkg::job_t wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output tchfb_pkg::job_t rd_data
);
    import tchfb_pkg::*;

    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= !wp_reg;
            end
            if (rd)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

endmodule

[sv/tchfb_back.sv]
// Back part: computes checksums and streams each frame header one word per transfer.
// Depends on tchfb_pkg.
module tchfb_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    output logic                job_ready,
    input  tchfb_pkg::job_t     job,
    input  logic [47:0]         own_mac,
    input  logic [31:0]         own_ip,
    input  logic [47:0]         peer_mac,
    input  logic [31:0]         peer_ip,
    input  logic [15:0]         peer_port,
    output logic                out_valid,
    input  logic                out_ready,
    output tchfb_pkg::out_item_t out_data
);
    import tchfb_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]  st_reg, st_next;
    job_t        cur_reg;
    logic [4:0]  idx_reg, idx_next;
    logic [15:0] ipck_reg, tcpck_reg, acc_reg, acc_next;
    logic [15:0] tacc_reg, tacc_next;
    logic [15:0] tlen;
    logic [15:0] w;
    logic [15:0] word_at;
    logic        ov_reg;
    out_item_t   od_reg;
    logic        slot_free;

    assign slot_free = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign job_ready = (st_reg == ST_IDLE) && slot_free;
    assign tlen = HDR_BYTES + {5'd0, cur_reg.plen};

    // Header word at the current index, checksum fields zero.
    always_comb
    begin
        unique case (idx_reg)
            5'd0:  w = peer_mac[47:32];
            5'd1:  w = peer_mac[31:16];
            5'd2:  w = peer_mac[15:0];
            5'd3:  w = own_mac[47:32];
            5'd4:  w = own_mac[31:16];
            5'd5:  w = own_mac[15:0];
            5'd6:  w = ETHERTYPE_IP;
            5'd7:  w = IP_VER_TOS;
            5'd8:  w = tlen;
            5'd9:  w = cur_reg.ident;
            5'd11: w = IP_TTL_PROTO;
            5'd13: w = own_ip[31:16];
            5'd14: w = own_ip[15:0];
            5'd15: w = peer_ip[31:16];
            5'd16: w = peer_ip[15:0];
            5'd17: w = cur_reg.lport;
            5'd18: w = peer_port;
            5'd19: w = cur_reg.seq[31:16];
            5'd20: w = cur_reg.seq[15:0];
            5'd21: w = cur_reg.ack[31:16];
            5'd22: w = cur_reg.ack[15:0];
            5'd23: w = cur_reg.flags;
            5'd24: w = cur_reg.window;
            5'd27: w = PROTO_TCP;
            5'd28: w = TCP_HDR_BYTES + {5'd0, cur_reg.plen};
            5'd29: w = cur_reg.psum;
            default: w = 16'd0;
        endcase
    end

    always_comb
    begin
        if (idx_reg == 5'd12)
        begin
            word_at = ipck_reg;
        end
        else if (idx_reg == 5'd25)
        begin
            word_at = tcpck_reg;
        end
        else
        begin
            word_at = w;
        end
    end

    // Sequencer: a checksum sweep over indices 7..29, then the word stream.
    // The IP sum covers indices 7..16; the TCP sum covers 13..29, which takes in
    // the addresses of the pseudo header.
    always_comb
    begin
        st_next   = st_reg;
        idx_next  = idx_reg;
        acc_next  = acc_reg;
        tacc_next = tacc_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (job_valid && slot_free && job.is_frame)
                begin
                    st_next   = ST_SUM;
                    idx_next  = 5'd7;
                    acc_next  = '0;
                    tacc_next = '0;
                end
            end
            ST_SUM:
            begin
                acc_next = oc_add(acc_reg, w);
                idx_next = idx_reg + 5'd1;
                if (idx_reg >= 5'd13)
                begin
                    tacc_next = oc_add(tacc_reg, w);
                end
                if (idx_reg == 5'd16)
                begin
                    acc_next = '0;
                end
                if (idx_reg == 5'd29)
                begin
                    st_next  = ST_EMIT;
                    idx_next = '0;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    idx_next = idx_reg + 5'd1;
                    if (idx_reg == FRAME_WORDS - 5'd1)
                    begin
                        st_next  = ST_IDLE;
                        idx_next = '0;
                    end
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_IDLE;
            idx_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            idx_reg <= idx_next;
            if ((st_reg == ST_IDLE && job_valid && slot_free && !job.is_frame)
                || (st_reg == ST_EMIT && slot_free))
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // Job copy, checksum results and the output register.
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        tacc_reg <= tacc_next;
        if (job_ready && job_valid)
        begin
            cur_reg <= job;
        end
        if (st_reg == ST_SUM && idx_reg == 5'd16)
        begin
            ipck_reg <= ~oc_add(acc_reg, w);
        end
        if (st_reg == ST_SUM && idx_reg == 5'd29)
        begin
            tcpck_reg <= ~oc_add(tacc_reg, w);
        end
        if (st_reg == ST_IDLE && job_valid && slot_free && !job.is_frame)
        begin
            od_reg.item_kind   <= 1'b1;
            od_reg.frame_word  <= '0;
            od_reg.last_word   <= 1'b1;
            od_reg.verdict     <= job.verdict;
            od_reg.data_length <= job.data_length;
        end
        else if (st_reg == ST_EMIT && slot_free)
        begin
            od_reg.item_kind   <= 1'b0;
            od_reg.frame_word  <= word_at;
            od_reg.last_word   <= (idx_reg == FRAME_WORDS - 5'd1);
            od_reg.verdict     <= VERD_IGNORED;
            od_reg.data_length <= '0;
        end
    end

endmodule

[sv/tcp_client_handshake_frame_builder.sv]
// TCP client frame builder, top level. Depends on tchfb_pkg, tchfb_front, tchfb_queue
// and tchfb_back. A verdict command passes through the front's job register, the
// queue and the back's output register to its one result transfer. A frame command
// (open, SYN+ACK answer, send) gives 27 header word transfers; the back end first
// sweeps header indices 7..29 to form both checksums with two 16-bit ones complement
// adders, then emits one word per cycle while the output is not stalled. The front
// keeps accepting commands into a two-entry queue while the back works.
// Configuration registers are written by index 0..4.
module tcp_client_handshake_frame_builder #(
    parameter int MAX_PAYLOAD = 1460
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tchfb_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tchfb_pkg::out_item_t out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [47:0]          cfg_data
);
    import tchfb_pkg::*;

    logic [47:0] own_mac_reg, peer_mac_reg;
    logic [31:0] own_ip_reg, peer_ip_reg;
    logic [15:0] peer_port_reg;
    logic        fj_valid, fj_ready, bj_valid, bj_ready;
    job_t        fj, bj;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg   <= '0;
            own_ip_reg    <= '0;
            peer_mac_reg  <= '0;
            peer_ip_reg   <= '0;
            peer_port_reg <= 16'd80;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_OWN_MAC:   own_mac_reg   <= cfg_data;
                REG_OWN_IP:    own_ip_reg    <= cfg_data[31:0];
                REG_PEER_MAC:  peer_mac_reg  <= cfg_data;
                REG_PEER_IP:   peer_ip_reg   <= cfg_data[31:0];
                REG_PEER_PORT: peer_port_reg <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    tchfb_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
    );

    tchfb_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
        .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
    );

    tchfb_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
        .own_mac(own_mac_reg), .own_ip(own_ip_reg),
        .peer_mac(peer_mac_reg), .peer_ip(peer_ip_reg), .peer_port(peer_port_reg),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

endmodule

[sv/tchfb_checker.sv]
// Port-level checker for the TCP client frame builder, bound to the top level.
// Depends on tchfb_pkg.
module tchfb_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input tchfb_pkg::out_item_t out_data,
    input logic                 cfg_ready
);
    import tchfb_pkg::*;

    // A stalled result transfer holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // A verdict is always the last result of its command.
    a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.item_kind |-> out_data.last_word)
        else $error("verdict not marked last");

    // Frame words carry no verdict or length.
    a_frame_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.item_kind |-> out_data.verdict == VERD_IGNORED
        && out_data.data_length == 16'd0)
        else $error("frame word with verdict fields");

    // Configuration is always taken.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("configuration not ready");

endmodule

bind tcp_client_handshake_frame_builder tchfb_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .cfg_ready(cfg_ready)
);
